/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on aclk, off while reset is low
`define STQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/stq_pkg.sv */
package stq_pkg;

    localparam int TIMER_SLOTS   = 16;
    localparam int COUNT_BITS    = 32;
    localparam int INTERVAL_BITS = 31;
    localparam int VALUE_BITS    = 32;

    localparam int SLOT_BITS = $clog2(TIMER_SLOTS);
    localparam int CNT_W     = $clog2(TIMER_SLOTS + 1);
    localparam int SUM_W     = (COUNT_BITS > INTERVAL_BITS) ? COUNT_BITS : INTERVAL_BITS;
    localparam int RAM_W     = COUNT_BITS + VALUE_BITS;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_START  = 1'b1;
    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_ZERO = 2'd1,
        STATUS_FULL = 2'd2
    } status_code_t;

    typedef struct packed {
        logic                          func;
        logic [INTERVAL_BITS-1:0]      interval;
        logic signed [VALUE_BITS-1:0]  user_value;
    } stq_in_t;

    typedef struct packed {
        logic                          kind;
        status_code_t                  status;
        logic signed [VALUE_BITS-1:0]  fired_value;
        logic                          last;
    } stq_out_t;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic start_commit;
        logic lookup;
        logic remove;
        logic keep;
        logic step;
        logic finish;
    } stq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_is_start;
        logic empty;
        logic due;
        logic held_valid;
        logic out_free;
        logic scan_last;
    } stq_flags_t;

endpackage

/* sv/stq_ram.sv */
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/stq_ctrl.sv */
`include "assert_macros.svh"

module stq_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  stq_pkg::stq_flags_t flags,
    output stq_pkg::stq_cmd_t   cmd
);

    import stq_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_LOOKUP,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take = 1'b1;
                    if (flags.in_is_start) begin
                        state_next = ST_START;
                    end else if (!flags.empty) begin
                        state_next = ST_LOOKUP;
                    end
                end
            end
            ST_START: begin
                if (flags.out_free) begin
                    cmd.start_commit = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // a second due timer has to push the held one out first
                if (!flags.due || !flags.held_valid || flags.out_free) begin
                    cmd.remove = flags.due;
                    cmd.keep   = !flags.due;
                    cmd.step   = 1'b1;
                    state_next = flags.scan_last ? ST_FLUSH : ST_LOOKUP;
                end
            end
            ST_FLUSH: begin
                if (!flags.held_valid || flags.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `STQ_ASSERT_SAME(a_flush_has_room, cmd.finish && flags.held_valid, flags.out_free,
        "final expiry word issued while output register busy")

endmodule

/* sv/stq_dp.sv */
`include "assert_macros.svh"

module stq_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  stq_pkg::stq_in_t    s_data,
    input  logic                m_ready,
    output logic                m_valid,
    output stq_pkg::stq_out_t   m_data,
    input  stq_pkg::stq_cmd_t   cmd,
    output stq_pkg::stq_flags_t flags
);

    import stq_pkg::*;

    stq_in_t                       item_reg;
    logic [COUNT_BITS-1:0]         tick_reg;
    logic [TIMER_SLOTS-1:0]        valid_reg;
    logic [SLOT_BITS-1:0]          order_reg [TIMER_SLOTS];
    logic [CNT_W-1:0]              count_reg;
    logic [SLOT_BITS-1:0]          rank_reg;
    logic [CNT_W-1:0]              removed_reg;
    logic [SLOT_BITS-1:0]          slot_reg;
    logic                          held_valid_reg;
    logic signed [VALUE_BITS-1:0]  held_value_reg;
    logic                          m_valid_reg;
    stq_out_t                      m_data_reg;

    logic [SLOT_BITS-1:0]          free_idx;
    logic [SLOT_BITS-1:0]          found_idx;
    logic                          full;
    logic                          out_free;
    logic                          out_load;
    logic                          start_ok;
    status_code_t                  start_status;
    logic [SUM_W-1:0]              deadline_sum;
    logic [COUNT_BITS-1:0]         new_deadline;
    logic [SLOT_BITS-1:0]          ram_rd_addr;
    logic [RAM_W-1:0]              ram_rd_data;
    logic [COUNT_BITS-1:0]         rd_deadline;
    logic [VALUE_BITS-1:0]         rd_payload;
    logic [CNT_W-1:0]              new_rank;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    // slot holding the current start rank; ranks are unique among pending timers
    always_comb begin
        found_idx = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (valid_reg[i] && order_reg[i] == rank_reg) begin
                found_idx = SLOT_BITS'(i);
            end
        end
    end

    assign full         = &valid_reg;
    assign out_free     = !m_valid_reg || m_ready;
    assign deadline_sum = SUM_W'(tick_reg) + SUM_W'(item_reg.interval);
    assign new_deadline = deadline_sum[COUNT_BITS-1:0];

    always_comb begin
        if (item_reg.interval == '0) begin
            start_status = STATUS_ZERO;
        end else if (full) begin
            start_status = STATUS_FULL;
        end else begin
            start_status = STATUS_OK;
        end
    end

    assign start_ok    = (start_status == STATUS_OK);
    assign ram_rd_addr = cmd.lookup ? found_idx : slot_reg;
    assign rd_deadline = ram_rd_data[RAM_W-1:VALUE_BITS];
    assign rd_payload  = ram_rd_data[VALUE_BITS-1:0];
    // surviving timers move down by the number removed ahead of them
    assign new_rank    = CNT_W'(rank_reg) - removed_reg;

    assign out_load = cmd.start_commit || ((cmd.remove || cmd.finish) && held_valid_reg);

    stq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TIMER_SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (cmd.start_commit && start_ok),
        .wr_addr (free_idx),
        .wr_data ({new_deadline, item_reg.user_value}),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            valid_reg      <= '0;
            count_reg      <= '0;
            rank_reg       <= '0;
            removed_reg    <= '0;
            held_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.take && s_data.func == FUNC_TICK) begin
                tick_reg    <= tick_reg + COUNT_BITS'(1);
                rank_reg    <= '0;
                removed_reg <= '0;
            end
            if (cmd.start_commit && start_ok) begin
                valid_reg[free_idx] <= 1'b1;
                count_reg           <= count_reg + CNT_W'(1);
            end
            if (cmd.remove) begin
                valid_reg[slot_reg] <= 1'b0;
                removed_reg         <= removed_reg + CNT_W'(1);
                held_valid_reg      <= 1'b1;
            end
            if (cmd.step) begin
                rank_reg <= rank_reg + SLOT_BITS'(1);
            end
            if (cmd.finish) begin
                count_reg      <= count_reg - removed_reg;
                held_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            item_reg <= s_data;
        end
        if (cmd.start_commit && start_ok) begin
            order_reg[free_idx] <= count_reg[SLOT_BITS-1:0];
        end
        if (cmd.keep) begin
            order_reg[slot_reg] <= new_rank[SLOT_BITS-1:0];
        end
        if (cmd.lookup) begin
            slot_reg <= found_idx;
        end
        if (cmd.remove) begin
            held_value_reg <= rd_payload;
        end
        if (cmd.start_commit) begin
            m_data_reg.kind        <= KIND_ACK;
            m_data_reg.status      <= start_status;
            m_data_reg.fired_value <= '0;
            m_data_reg.last        <= 1'b1;
        end else if (out_load) begin
            m_data_reg.kind        <= KIND_EXPIRY;
            m_data_reg.status      <= STATUS_OK;
            m_data_reg.fired_value <= held_value_reg;
            m_data_reg.last        <= cmd.finish;
        end
    end

    always_comb begin
        flags.in_is_start = (s_data.func == FUNC_START);
        flags.empty       = (count_reg == '0);
        flags.due         = (rd_deadline == tick_reg);
        flags.held_valid  = held_valid_reg;
        flags.out_free    = out_free;
        flags.scan_last   = (CNT_W'(rank_reg) + CNT_W'(1)) == count_reg;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `STQ_ASSERT_SAME(a_load_when_free, out_load, out_free,
        "output register overwritten before it was taken")
    `STQ_ASSERT_SAME(a_remove_pending, cmd.remove, valid_reg[slot_reg] && flags.due,
        "removing a slot that is not a due pending timer")
    `STQ_ASSERT_NEXT(a_count_matches, cmd.finish || cmd.start_commit,
        count_reg == CNT_W'($countones(valid_reg)),
        "pending count out of step with slot valid bits")

endmodule

/* sv/sorted_timer_queue.sv */
// channel | ports                  | word      | accepted when
// --------+------------------------+-----------+--------------------
// input   | s_valid s_ready s_data | stq_in_t  | s_valid && s_ready
// result  | m_valid m_ready m_data | stq_out_t | m_valid && m_ready
//
// a start is accepted, then its acknowledgement goes into the output register once that is free
// a tick with no pending timer leaves the block idle; with pending timers it runs a scan:
// each start rank is looked up, its deadline read from the slot ram and compared
// reset clears the tick counter, slot valid bits and output valid bit; slot ram is not cleared
// a held output word stalls the scan only when another expiry or an ack needs the register

module sorted_timer_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  stq_pkg::stq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output stq_pkg::stq_out_t m_data
);

    import stq_pkg::*;

    stq_cmd_t   cmd;
    stq_flags_t flags;

    stq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    stq_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cmd     (cmd),
        .flags   (flags)
    );

endmodule
